// ===== rtl/lz4_stream_decompressor_defines.svh =====
// ----------------------------------------------------------------------------
// LZ4 stream decompressor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LZ4_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZ4_STREAM_DECOMPRESSOR_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define LZ4SD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lz4sd: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define LZ4SD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz4sd: implication violated");

// The consequent holds in the cycle after the antecedent.
`define LZ4SD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz4sd: next-cycle implication violated");

`endif

// ===== rtl/lz4sd_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4sd_pkg
// Types, phase codes and constants shared by the LZ4 stream decompressor.
// ----------------------------------------------------------------------------
package lz4sd_pkg;

  localparam int CNT_W              = 24;
  localparam int HISTORY_DEPTH_DEF  = 65536;
  localparam int HEADER_BYTES_DEF   = 11;

  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [3:0]       NIBBLE_EXT = 4'hF;
  localparam logic [7:0]       BYTE_EXT   = 8'hFF;
  localparam int               TAIL_BYTES = 12;
  localparam int               MIN_MATCH  = 4;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_TOKEN     = 4'd1,
    PH_LIT_EXT   = 4'd2,
    PH_LITERALS  = 4'd3,
    PH_OFF_LO    = 4'd4,
    PH_OFF_HI    = 4'd5,
    PH_MATCH_EXT = 4'd6,
    PH_COPY      = 4'd7,
    PH_DONE      = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REJECT     = 2'd1,
    ST_BAD_OFFSET = 2'd2
  } status_t;

  // Result of one accepted item as decided by the sequence decoder.
  typedef struct packed {
    logic             emit;
    logic             copy;
    logic [7:0]       lit;
    logic [CNT_W-1:0] pos;
    logic             pend;
    logic             fin;
    status_t          status;
  } step_t;

endpackage

// ===== rtl/lz4sd_history.sv =====
// ----------------------------------------------------------------------------
// lz4sd_history
// Decompressed-byte history: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lz4sd_history
  import lz4sd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int ADDR_W        = $clog2(HISTORY_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled copy keeps its byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lz4sd_decoder.sv =====
// ----------------------------------------------------------------------------
// lz4sd_decoder
// Sequence parser: header skip, token, length extension, offset and copy
// control, plus the history pointers for each accepted item.
// ----------------------------------------------------------------------------
`include "lz4_stream_decompressor_defines.svh"

module lz4sd_decoder
  import lz4sd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
  parameter int ADDR_W        = $clog2(HISTORY_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              accept,
  input  logic              mode,
  input  logic [7:0]        in_byte,
  output step_t             step,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] wr_addr
);

  localparam phase_t PH_RESET = (HEADER_BYTES == 0) ? PH_TOKEN : PH_HEADER;

  logic [CNT_W-1:0]  source_length;
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  in_count, in_count_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic [CNT_W-1:0]  run_length, run_length_next;
  logic [3:0]        match_nibble, match_nibble_next;
  logic [15:0]       match_distance, match_distance_next;
  logic [ADDR_W-1:0] hist_ptr, hist_ptr_next;

  logic              reject, bad_off, emit, copy_step;
  logic [CNT_W-1:0]  in_inc, run_dec, run_plus_b, run_plus_b4, out_inc;
  logic [CNT_W:0]    sum_b;
  logic [CNT_W+1:0]  sum_b4;
  logic              src_end, near_end, off_bad;
  logic [15:0]       dist_cand;
  logic [ADDR_W:0]   rd_diff;

  // Shared arithmetic for the item at hand.
  always_comb begin
    in_inc      = (in_count == CNT_MAX) ? CNT_MAX : in_count + 1'b1;
    run_dec     = run_length - 1'b1;
    out_inc     = out_count + 1'b1;
    sum_b       = {1'b0, run_length} + (CNT_W+1)'(in_byte);
    run_plus_b  = sum_b[CNT_W] ? CNT_MAX : sum_b[CNT_W-1:0];
    sum_b4      = {2'b00, run_length} + (CNT_W+2)'(in_byte) + (CNT_W+2)'(MIN_MATCH);
    run_plus_b4 = (sum_b4[CNT_W+1:CNT_W] != 2'b00) ? CNT_MAX : sum_b4[CNT_W-1:0];
    src_end     = in_count >= source_length;
    near_end    = ({1'b0, in_inc} + (CNT_W+1)'(TAIL_BYTES)) >= {1'b0, source_length};
    dist_cand   = (phase == PH_OFF_HI) ? {in_byte, match_distance[7:0]} : match_distance;
    off_bad     = (dist_cand == 16'd0) || ({8'd0, dist_cand} > out_count);
    // A valid offset never exceeds out_count, so one wrap correction suffices.
    rd_diff     = {1'b0, hist_ptr} - (ADDR_W+1)'(match_distance);
    if (rd_diff[ADDR_W]) begin
      rd_diff = rd_diff + (ADDR_W+1)'(HISTORY_DEPTH);
    end
  end

  // Next state.
  always_comb begin
    phase_next          = phase;
    in_count_next       = in_count;
    out_count_next      = out_count;
    run_length_next     = run_length;
    match_nibble_next   = match_nibble;
    match_distance_next = match_distance;
    hist_ptr_next       = hist_ptr;
    reject              = 1'b0;
    bad_off             = 1'b0;
    emit                = 1'b0;
    copy_step           = 1'b0;

    unique case (phase)
      PH_DONE: begin
        reject = 1'b1;
      end
      PH_COPY: begin
        if (!mode) begin
          reject = 1'b1;
        end else begin
          copy_step       = 1'b1;
          emit            = 1'b1;
          run_length_next = run_dec;
          if (run_dec == '0) begin
            phase_next = PH_TOKEN;
          end
        end
      end
      default: begin
        if (mode) begin
          reject = 1'b1;
        end else if (phase == PH_TOKEN && src_end) begin
          reject     = 1'b1;
          phase_next = PH_DONE;
        end else begin
          in_count_next = in_inc;
          case (phase)
            PH_HEADER: begin
              if (in_inc >= CNT_W'(HEADER_BYTES)) begin
                phase_next = PH_TOKEN;
              end
            end
            PH_TOKEN: begin
              match_nibble_next = in_byte[3:0];
              if (in_byte[7:4] == NIBBLE_EXT) begin
                run_length_next = CNT_W'(NIBBLE_EXT);
                phase_next      = PH_LIT_EXT;
              end else if (in_byte[7:4] != 4'd0) begin
                run_length_next = CNT_W'(in_byte[7:4]);
                phase_next      = PH_LITERALS;
              end else begin
                phase_next = near_end ? PH_DONE : PH_OFF_LO;
              end
            end
            PH_LIT_EXT: begin
              run_length_next = run_plus_b;
              if (in_byte != BYTE_EXT) begin
                phase_next = PH_LITERALS;
              end
            end
            PH_LITERALS: begin
              emit            = 1'b1;
              run_length_next = run_dec;
              if (run_dec == '0) begin
                phase_next = near_end ? PH_DONE : PH_OFF_LO;
              end
            end
            PH_OFF_LO: begin
              match_distance_next = {8'd0, in_byte};
              phase_next          = PH_OFF_HI;
            end
            PH_OFF_HI: begin
              match_distance_next = dist_cand;
              if (match_nibble == NIBBLE_EXT) begin
                run_length_next = CNT_W'(NIBBLE_EXT);
                phase_next      = PH_MATCH_EXT;
              end else if (off_bad) begin
                bad_off         = 1'b1;
                run_length_next = '0;
                phase_next      = PH_TOKEN;
              end else begin
                run_length_next = CNT_W'(match_nibble) + CNT_W'(MIN_MATCH);
                phase_next      = PH_COPY;
              end
            end
            PH_MATCH_EXT: begin
              run_length_next = run_plus_b;
              if (in_byte != BYTE_EXT) begin
                if (off_bad) begin
                  bad_off         = 1'b1;
                  run_length_next = '0;
                  phase_next      = PH_TOKEN;
                end else begin
                  run_length_next = run_plus_b4;
                  phase_next      = PH_COPY;
                end
              end
            end
            default: begin
              phase_next = PH_DONE;
            end
          endcase
        end
      end
    endcase

    if (emit) begin
      out_count_next = out_inc;
      // The history pointer follows out_count modulo the history depth.
      if (out_count == CNT_MAX || hist_ptr == ADDR_W'(HISTORY_DEPTH - 1)) begin
        hist_ptr_next = '0;
      end else begin
        hist_ptr_next = hist_ptr + 1'b1;
      end
    end
  end

  // Outputs.
  always_comb begin
    step.emit   = emit;
    step.copy   = copy_step;
    step.lit    = in_byte;
    step.pos    = out_count;
    step.pend   = (phase_next == PH_COPY);
    step.fin    = (phase_next == PH_DONE) ||
                  (phase_next == PH_TOKEN && in_count_next >= source_length);
    step.status = reject ? ST_REJECT : (bad_off ? ST_BAD_OFFSET : ST_OK);
    rd_en       = accept && copy_step;
    rd_addr     = rd_diff[ADDR_W-1:0];
    wr_addr     = hist_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_length  <= '0;
      phase          <= PH_RESET;
      in_count       <= '0;
      out_count      <= '0;
      run_length     <= '0;
      match_nibble   <= '0;
      match_distance <= '0;
      hist_ptr       <= '0;
    end else begin
      if (cfg_write) begin
        source_length <= cfg_data;
      end
      if (accept) begin
        phase          <= phase_next;
        in_count       <= in_count_next;
        out_count      <= out_count_next;
        run_length     <= run_length_next;
        match_nibble   <= match_nibble_next;
        match_distance <= match_distance_next;
        hist_ptr       <= hist_ptr_next;
      end
    end
  end

  `LZ4SD_ASSERT_IMPL(a_lit_run_nonzero, phase == PH_LITERALS, run_length != '0)
  `LZ4SD_ASSERT_IMPL(a_copy_run_nonzero, phase == PH_COPY, run_length != '0)
  `LZ4SD_ASSERT_IMPL(a_copy_dist_nonzero, phase == PH_COPY, match_distance != 16'd0)

endmodule

// ===== rtl/lz4_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz4_stream_decompressor
// LZ4 block decoder fed one compressed byte or one copy request per item,
// with a synchronous history memory for match copies.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | mode, in_byte
//  result   | res_valid / res_stall| out_valid, out_byte, out_position,
//           |                      | copy_pending, finished, status
//  config   | cfg_write            | cfg_data (source_length)
//
// One item per cycle while res_stall is low; an accepted item's result goes through the
// read stage, then the output register, before it is on the port.
// A copy that reads the byte being written back in the same cycle takes it
// from a forwarding register instead of the history memory.
// Reset is synchronous; the history memory is not cleared.
// A stalled result holds; one more item fits in the read stage, then the input stalls.
// ----------------------------------------------------------------------------
`include "lz4_stream_decompressor_defines.svh"

module lz4_stream_decompressor
  import lz4sd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  input  logic             res_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] out_position,
  output logic             copy_pending,
  output logic             finished,
  output logic [1:0]       status
);

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);

  logic              accept;
  step_t             step;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        rd_data;

  logic              s1_valid;
  step_t             s1_step;
  logic [ADDR_W-1:0] s1_wr_addr;
  logic              s1_fwd;
  logic [7:0]        s1_fwd_data;
  logic [7:0]        s1_byte;
  logic              s1_move;
  logic              fwd_hit;

  assign s1_move  = s1_valid && (!res_valid || !res_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (!s1_step.emit) begin
      s1_byte = 8'd0;
    end else if (s1_step.copy) begin
      s1_byte = s1_fwd ? s1_fwd_data : rd_data;
    end else begin
      s1_byte = s1_step.lit;
    end
  end

  // The read stage writes its byte back as it moves on; a read issued in that
  // same cycle at the same address must see the new byte.
  assign fwd_hit = s1_move && s1_step.emit && (s1_wr_addr == rd_addr);

  lz4sd_decoder #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .accept   (accept),
    .mode     (mode),
    .in_byte  (in_byte),
    .step     (step),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  lz4sd_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_history (
    .clk    (clk),
    .wr_en  (s1_move && s1_step.emit),
    .wr_addr(s1_wr_addr),
    .wr_data(s1_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step    <= step;
      s1_wr_addr <= wr_addr;
      s1_fwd     <= step.copy && fwd_hit;
      if (step.copy && fwd_hit) begin
        s1_fwd_data <= s1_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_valid    <= s1_step.emit;
      out_byte     <= s1_byte;
      out_position <= s1_step.pos;
      copy_pending <= s1_step.pend;
      finished     <= s1_step.fin;
      status       <= s1_step.status;
    end
  end

  `LZ4SD_ASSERT_IMPL(a_fwd_only_copy, s1_valid && s1_fwd, s1_step.copy && s1_step.emit)
  `LZ4SD_ASSERT_IMPL(a_idle_byte_zero, res_valid && !out_valid, out_byte == 8'd0)
  `LZ4SD_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_move, s1_valid && $stable(s1_step))
  `LZ4SD_ASSERT_IMPL(a_copy_no_reject, res_valid && out_valid, status != ST_REJECT)

endmodule
